// ----- hw/rtl/skl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and constants for the synchrotron kernel lookup.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int X_W    = 23;
	localparam int F_W    = 24;
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ROM_SIZE = 53;

	localparam logic [1:0] REGION_TABLE = 2'd0;
	localparam logic [1:0] REGION_CBRT  = 2'd1;
	localparam logic [1:0] REGION_EXP   = 2'd2;

	localparam logic [X_W-1:0] CBRT_LIMIT  = 23'd655;
	localparam logic [X_W-1:0] EXP_LIMIT   = 23'd655360;
	localparam logic [X_W-1:0] FLUSH_LIMIT = 23'd1310720;
	localparam logic [MUL_B_W-1:0] K_CBRT = 32'd140870;
	localparam logic [MUL_B_W-1:0] K_EXP  = 32'd82136;

	typedef struct packed {
		logic [F_W-1:0] kernel_value;
		logic [1:0]     region;
	} skl_res_t;

	typedef struct packed {
		logic busy;
		logic done;
	} skl_stat_t;

	localparam logic [X_W-1:0] ROM_X [ROM_SIZE] = '{
		23'd655, 23'd1311, 23'd1966, 23'd2621, 23'd3277, 23'd3932, 23'd4588, 23'd5243,
		23'd5898, 23'd6554, 23'd7864, 23'd9175, 23'd10486, 23'd11796, 23'd13107,
		23'd14418, 23'd15729, 23'd17039, 23'd18350, 23'd19661, 23'd26214, 23'd32768,
		23'd39322, 23'd45875, 23'd52429, 23'd58982, 23'd65536, 23'd72090, 23'd78643,
		23'd85197, 23'd91750, 23'd98304, 23'd104858, 23'd111411, 23'd117965,
		23'd124518, 23'd131072, 23'd163840, 23'd196608, 23'd229376, 23'd262144,
		23'd294912, 23'd327680, 23'd360448, 23'd393216, 23'd425984, 23'd458752,
		23'd491520, 23'd524288, 23'd557056, 23'd589824, 23'd622592, 23'd655360
	};

	localparam logic [F_W-1:0] ROM_F [ROM_SIZE] = '{
		24'd7465861, 24'd9180493, 24'd10294500, 24'd11119939, 24'd11770895,
		24'd12301055, 24'd12745651, 24'd13123138, 24'd13446939, 24'd13727118,
		24'd14183458, 24'd14532424, 24'd14800860, 24'd15003864, 24'd15156537,
		24'd15265589, 24'd15339409, 24'd15383029, 24'd15399807, 24'd15396451,
		24'd15131371, 24'd14609600, 24'd13950255, 24'd13218768, 24'd12455405,
		24'd11687009, 24'd10928679, 24'd10192159, 24'd9484160, 24'd8808038,
		24'd8165471, 24'd7559814, 24'd6991066, 24'd6457550, 24'd5957589,
		24'd5492861, 24'd5060008, 24'd3323566, 24'd2157550, 24'd1387476,
		24'd885837, 24'd563714, 24'd357355, 24'd224815, 24'd140425, 24'd88919,
		24'd55700, 24'd33722, 24'd21810, 24'd13623, 24'd8506, 24'd5335, 24'd3188
	};

	// floor(2^32 / n) for the series divisors; n = 1 never comes here
	function automatic logic [MUL_B_W-1:0] recip(input logic [4:0] n);
		logic [MUL_B_W-1:0] r;
		case (n)
			5'd2:    r = 32'd2147483648;
			5'd3:    r = 32'd1431655765;
			5'd4:    r = 32'd1073741824;
			5'd5:    r = 32'd858993459;
			5'd6:    r = 32'd715827882;
			5'd7:    r = 32'd613566756;
			5'd8:    r = 32'd536870912;
			5'd9:    r = 32'd477218588;
			5'd10:   r = 32'd429496729;
			5'd11:   r = 32'd390451572;
			5'd12:   r = 32'd357913941;
			5'd13:   r = 32'd330382099;
			5'd14:   r = 32'd306783378;
			5'd15:   r = 32'd286331153;
			5'd16:   r = 32'd268435456;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/skl_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module skl_mul
	import skl_pkg::*;
(
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

// ----- hw/rtl/skl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_seq
// Sequencer and datapath: table scan, cube root, series exponential and
// square root; all but the table scan drive the one shared multiplier.
// ----------------------------------------------------------------------------
module skl_seq
	import skl_pkg::*;
#(
	parameter int SEARCHED_ENTRIES = 53
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [X_W-1:0]     x_in,
	input  logic               ack,
	input  logic [MUL_P_W-1:0] prod,
	output logic [MUL_A_W-1:0] mul_a,
	output logic [MUL_B_W-1:0] mul_b,
	output skl_stat_t          stat,
	output skl_res_t           res
);

	localparam int N_ENT = (SEARCHED_ENTRIES > ROM_SIZE) ? ROM_SIZE :
		((SEARCHED_ENTRIES < 1) ? 1 : SEARCHED_ENTRIES);
	localparam logic [5:0] LAST_IDX = 6'(N_ENT - 1);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_C_SQ  = 5'd1;
	localparam logic [4:0] ST_C_CU  = 5'd2;
	localparam logic [4:0] ST_C_CMP = 5'd3;
	localparam logic [4:0] ST_C_FIN = 5'd4;
	localparam logic [4:0] ST_C_RND = 5'd5;
	localparam logic [4:0] ST_T_SCN = 5'd6;
	localparam logic [4:0] ST_T_OUT = 5'd7;
	localparam logic [4:0] ST_E_MUL = 5'd8;
	localparam logic [4:0] ST_E_SHR = 5'd9;
	localparam logic [4:0] ST_E_REC = 5'd10;
	localparam logic [4:0] ST_E_QN  = 5'd11;
	localparam logic [4:0] ST_E_COR = 5'd12;
	localparam logic [4:0] ST_E_ACC = 5'd13;
	localparam logic [4:0] ST_E_MIN = 5'd14;
	localparam logic [4:0] ST_E_SQ  = 5'd15;
	localparam logic [4:0] ST_E_SQR = 5'd16;
	localparam logic [4:0] ST_S_SQ  = 5'd17;
	localparam logic [4:0] ST_S_CMP = 5'd18;
	localparam logic [4:0] ST_E_MS  = 5'd19;
	localparam logic [4:0] ST_E_MK  = 5'd20;
	localparam logic [4:0] ST_E_RND = 5'd21;
	localparam logic [4:0] ST_DONE  = 5'd22;

	logic [4:0]       st_q;
	logic [X_W-1:0]   x_q;
	logic [1:0]       region_q;
	logic [F_W-1:0]   f_q;
	logic [19:0]      r_q;
	logic [4:0]       cnt_q;
	logic [5:0]       idx_q;
	logic [5:0]       best_q;
	logic [X_W-1:0]   bestd_q;
	logic [31:0]      term_q;
	logic [31:0]      a_q;
	logic [31:0]      q_q;
	logic [33:0]      acc_q;
	logic [4:0]       n_q;
	logic [31:0]      m_q;
	logic [4:0]       e_q;
	logic [2:0]       k_q;

	logic [19:0]      t;
	logic [30:0]      y;
	logic [X_W-1:0]   rom_x_cur;
	logic [X_W-1:0]   delta;
	logic [31:0]      rem;
	logic [5:0]       sh;
	logic [51:0]      rnd;
	logic [51:0]      sum;
	logic [36:0]      cbrt_sum;

	assign t         = r_q | (20'd1 << cnt_q);
	assign y         = {x_q[20:0], 10'b0};
	assign rom_x_cur = ROM_X[idx_q];
	assign delta     = (x_q >= rom_x_cur) ? (x_q - rom_x_cur) : (rom_x_cur - x_q);
	assign rem       = a_q - prod[31:0];
	assign sh        = 6'(e_q) + 6'd20;
	assign rnd       = 52'd1 << (sh - 6'd1);
	assign sum       = 52'(prod[48:0]) + rnd;
	assign cbrt_sum  = 37'(prod[35:0]) + 37'd2048;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q) inside
			ST_C_SQ, ST_S_SQ: begin
				mul_a = MUL_A_W'(t);
				mul_b = MUL_B_W'(t);
			end
			ST_C_CU: begin
				mul_a = prod[35:0];
				mul_b = MUL_B_W'(t);
			end
			ST_C_FIN: begin
				mul_a = MUL_A_W'(r_q);
				mul_b = K_CBRT;
			end
			ST_E_MUL: begin
				mul_a = MUL_A_W'(term_q);
				mul_b = MUL_B_W'(y);
			end
			ST_E_REC: begin
				mul_a = MUL_A_W'(a_q);
				mul_b = recip(n_q);
			end
			ST_E_QN: begin
				mul_a = MUL_A_W'(prod[63:32]);
				mul_b = MUL_B_W'(n_q);
			end
			ST_E_SQ: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = m_q;
			end
			ST_E_MS: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = MUL_B_W'(r_q);
			end
			ST_E_MK: begin
				mul_a = MUL_A_W'(prod[51:20]);
				mul_b = K_EXP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						x_q <= x_in;
						if (x_in <= CBRT_LIMIT) begin
							region_q <= REGION_CBRT;
							r_q      <= '0;
							cnt_q    <= 5'd17;
							st_q     <= ST_C_SQ;
						end else if (x_in > EXP_LIMIT) begin
							region_q <= REGION_EXP;
							if (x_in >= FLUSH_LIMIT) begin
								f_q  <= '0;
								st_q <= ST_DONE;
							end else begin
								term_q <= 32'h8000_0000;
								acc_q  <= 34'h0_8000_0000;
								n_q    <= 5'd1;
								st_q   <= ST_E_MUL;
							end
						end else begin
							region_q <= REGION_TABLE;
							idx_q    <= '0;
							st_q     <= ST_T_SCN;
						end
					end
				end
				ST_C_SQ: st_q <= ST_C_CU;
				ST_C_CU: st_q <= ST_C_CMP;
				ST_C_CMP: begin
					if (prod <= MUL_P_W'({x_q[9:0], 44'b0})) begin
						r_q <= t;
					end
					if (cnt_q == '0) begin
						st_q <= ST_C_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
						st_q  <= ST_C_SQ;
					end
				end
				ST_C_FIN: st_q <= ST_C_RND;
				ST_C_RND: begin
					f_q  <= cbrt_sum[35:12];
					st_q <= ST_DONE;
				end
				ST_T_SCN: begin
					if (idx_q == '0 || delta < bestd_q) begin
						bestd_q <= delta;
						best_q  <= idx_q;
					end
					if (idx_q == LAST_IDX) begin
						st_q <= ST_T_OUT;
					end else begin
						idx_q <= idx_q + 6'd1;
					end
				end
				ST_T_OUT: begin
					f_q  <= ROM_F[best_q];
					st_q <= ST_DONE;
				end
				ST_E_MUL: st_q <= ST_E_SHR;
				ST_E_SHR: begin
					// first term needs no divide
					if (n_q == 5'd1) begin
						term_q <= prod[62:31];
						st_q   <= ST_E_ACC;
					end else begin
						a_q  <= prod[62:31];
						st_q <= ST_E_REC;
					end
				end
				ST_E_REC: st_q <= ST_E_QN;
				ST_E_QN: begin
					q_q  <= prod[63:32];
					st_q <= ST_E_COR;
				end
				ST_E_COR: begin
					// reciprocal estimate is at most one low
					term_q <= (rem >= 32'(n_q)) ? (q_q + 32'd1) : q_q;
					st_q   <= ST_E_ACC;
				end
				ST_E_ACC: begin
					if (n_q[0]) begin
						acc_q <= acc_q - 34'(term_q);
					end else begin
						acc_q <= acc_q + 34'(term_q);
					end
					if (n_q == 5'd16) begin
						st_q <= ST_E_MIN;
					end else begin
						n_q  <= n_q + 5'd1;
						st_q <= ST_E_MUL;
					end
				end
				ST_E_MIN: begin
					m_q  <= {acc_q[30:0], 1'b0};
					e_q  <= '0;
					k_q  <= '0;
					st_q <= ST_E_SQ;
				end
				ST_E_SQ: st_q <= ST_E_SQR;
				ST_E_SQR: begin
					// renormalize after each squaring
					if (prod[63]) begin
						m_q <= prod[63:32];
						e_q <= {e_q[3:0], 1'b0};
					end else begin
						m_q <= prod[62:31];
						e_q <= {e_q[3:0], 1'b1};
					end
					if (k_q == 3'd4) begin
						r_q   <= '0;
						cnt_q <= 5'd19;
						st_q  <= ST_S_SQ;
					end else begin
						k_q  <= k_q + 3'd1;
						st_q <= ST_E_SQ;
					end
				end
				ST_S_SQ: st_q <= ST_S_CMP;
				ST_S_CMP: begin
					if (prod <= MUL_P_W'({x_q, 16'b0})) begin
						r_q <= t;
					end
					if (cnt_q == '0) begin
						st_q <= ST_E_MS;
					end else begin
						cnt_q <= cnt_q - 5'd1;
						st_q  <= ST_S_SQ;
					end
				end
				ST_E_MS: st_q <= ST_E_MK;
				ST_E_MK: st_q <= ST_E_RND;
				ST_E_RND: begin
					f_q  <= F_W'(sum >> sh);
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ack) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.busy        = (st_q != ST_IDLE);
	assign stat.done        = (st_q == ST_DONE);
	assign res.kernel_value = f_q;
	assign res.region       = region_q;

endmodule

// ----- hw/rtl/synchrotron_kernel_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// synchrotron_kernel_lookup
// Synchrotron kernel F(x) from a Q7.16 argument, Q0.24 result.
// ----------------------------------------------------------------------------
// One word at a time. A table word scans the ROM entries, one entry compared per
// cycle; a cube-root word finds 18 result bits, with a squaring and a cubing
// pass each; an exponential word sums 16 series terms, then takes five
// squarings and a 20-bit square root; arguments of 20 or more return zero.
// Cube root and exponential run every multiply through the one shared 36x32
// multiplier. The input stalls until the result has moved into the output
// register, which holds it until taken.
module synchrotron_kernel_lookup
	import skl_pkg::*;
#(
	parameter int SEARCHED_ENTRIES = 53
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [X_W-1:0]   x_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [F_W-1:0]   kernel_value,
	output logic [1:0]       region
);

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;
	skl_stat_t          stat;
	skl_res_t           res;
	logic               load;
	logic               out_valid_q;
	logic [F_W-1:0]     kernel_q;
	logic [1:0]         region_q;

	skl_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	skl_seq #(
		.SEARCHED_ENTRIES (SEARCHED_ENTRIES)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && !in_stall),
		.x_in   (x_value),
		.ack    (load),
		.prod   (prod),
		.mul_a  (mul_a),
		.mul_b  (mul_b),
		.stat   (stat),
		.res    (res)
	);

	assign in_stall = stat.busy;
	assign load     = stat.done && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kernel_q <= res.kernel_value;
			region_q <= res.region;
		end
	end

	assign out_valid    = out_valid_q;
	assign kernel_value = kernel_q;
	assign region       = region_q;

endmodule

// ----- hw/rtl/skl_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_chk
// Port-level checks for the synchrotron kernel lookup, bound to the top.
// ----------------------------------------------------------------------------
module skl_chk
	import skl_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  logic           out_valid,
	input  logic           out_stall,
	input  logic [F_W-1:0] kernel_value,
	input  logic [1:0]     region
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kernel_value) && $stable(region))
		else $error("stalled output word changed");

	// go busy once a word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous word in flight");

	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (region == REGION_TABLE || region == REGION_CBRT ||
			region == REGION_EXP))
		else $error("unknown region code");

	// table results lie within the ROM value range
	a_table_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region == REGION_TABLE |->
			kernel_value >= 24'd3188 && kernel_value <= 24'd15399807)
		else $error("table result out of range");

endmodule

bind synchrotron_kernel_lookup skl_chk u_skl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kernel_value (kernel_value),
	.region       (region)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed check of the synchrotron kernel lookup: a predictor
// computes F(x) and the region for every accepted argument, and a scoreboard
// compares each result word in order.
// ----------------------------------------------------------------------------
module testbench;
	import skl_pkg::*;

	localparam int WATCH_LIMIT = 20000;

	class kernel_scoreboard;
		logic [F_W-1:0] want_f [$];
		logic [1:0]     want_r [$];
		int mismatches = 0;
		int checked = 0;

		static function logic [63:0] cube_root(input logic [63:0] n);
			logic [63:0] r, t;
			r = 0;
			for (int b = 17; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t * t <= n) r = t;
			end
			return r;
		endfunction

		static function logic [63:0] square_root(input logic [63:0] n);
			logic [63:0] r, t;
			r = 0;
			for (int b = 19; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n) r = t;
			end
			return r;
		endfunction

		static function logic [F_W-1:0] exp_tail(input logic [X_W-1:0] v);
			logic [63:0] y, term, pos, neg, m, s, a, b, p;
			int e;
			if (v >= FLUSH_LIMIT) return '0;
			y = 64'(v) << 10;
			term = 64'd1 << 31;
			pos = term;
			neg = 0;
			for (int n = 1; n <= 16; n++) begin
				term = ((term * y) >> 31) / n;
				if (n % 2) neg += term;
				else pos += term;
			end
			m = (pos - neg) << 1;
			e = 0;
			for (int k = 0; k < 5; k++) begin
				p = m * m;
				if (p[63]) begin
					m = p >> 32;
					e = 2 * e;
				end else begin
					m = p >> 31;
					e = 2 * e + 1;
				end
			end
			if (e > 40) return '0;
			s = square_root(64'(v) << 16);
			a = (m * s) >> 20;
			b = a * K_EXP;
			return F_W'((b + (64'd1 << (19 + e))) >> (20 + e));
		endfunction

		static function logic [F_W-1:0] nearest_value(input logic [X_W-1:0] v);
			int best;
			logic [X_W-1:0] d, bestd;
			best = 0;
			bestd = 0;
			for (int i = 0; i < ROM_SIZE; i++) begin
				d = (v >= ROM_X[i]) ? v - ROM_X[i] : ROM_X[i] - v;
				if (i == 0 || d < bestd) begin
					bestd = d;
					best = i;
				end
			end
			return ROM_F[best];
		endfunction

		function void note_argument(input logic [X_W-1:0] v);
			logic [63:0] r;
			if (v <= CBRT_LIMIT) begin
				r = cube_root(64'(v) << 44);
				want_f.push_back(F_W'((r * K_CBRT + 64'd2048) >> 12));
				want_r.push_back(REGION_CBRT);
			end else if (v > EXP_LIMIT) begin
				want_f.push_back(exp_tail(v));
				want_r.push_back(REGION_EXP);
			end else begin
				want_f.push_back(nearest_value(v));
				want_r.push_back(REGION_TABLE);
			end
		endfunction

		function void check_result(input logic [F_W-1:0] f, input logic [1:0] r);
			logic [F_W-1:0] ef;
			logic [1:0] er;
			checked++;
			if (want_f.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kernel_value=%0d region=%0d", f, r);
				return;
			end
			ef = want_f.pop_front();
			er = want_r.pop_front();
			if (ef !== f || er !== r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: kernel_value exp %0d got %0d, region exp %0d got %0d",
						ef, f, er, r);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [X_W-1:0] x_value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [F_W-1:0] kernel_value;
	logic [1:0] region;

	kernel_scoreboard board = new();
	int idle_cycles = 0;
	int sent = 0;
	bit sending_done = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	synchrotron_kernel_lookup DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .x_value(x_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.kernel_value(kernel_value), .region(region)
	);

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 4);
	endfunction

	function automatic logic [X_W-1:0] random_argument();
		int i;
		case ($urandom_range(0, 9))
			0: return X_W'($urandom_range(0, 655));
			1: return X_W'($urandom_range(656, 1310720));
			2: return X_W'($urandom_range(655361, 1310719));
			3: return X_W'($urandom);
			4: begin
				// land at the midpoint of two neighbouring ROM abscissas, rounded either way, to hit ties
				i = $urandom_range(0, ROM_SIZE - 2);
				return X_W'((ROM_X[i] + ROM_X[i + 1] + $urandom_range(0, 1)) / 2);
			end
			5: begin
				i = $urandom_range(0, ROM_SIZE - 1);
				return X_W'(32'(ROM_X[i]) + $urandom_range(0, 2) - 32'd1);
			end
			default: return X_W'($urandom_range(656, 655360));
		endcase
	endfunction

	// valid stays up from one word to the next when there is no gap
	task automatic send_argument(input logic [X_W-1:0] v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		x_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_argument(v);
		sent++;
	endtask

	// hold stall high at random, sampled results at the rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 3) == 0) out_stall <= 1;
			else if ($urandom_range(0, 49) == 0) out_stall <= 1;
			else out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(kernel_value, region);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("watchdog: no progress, %0d words still expected", board.want_f.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [X_W-1:0] directed [$];
		directed = '{23'd0, 23'd1, 23'd654, 23'd655, 23'd656, 23'd983, 23'd984,
			23'd1311, 23'd655359, 23'd655360, 23'd655361, 23'd1310719, 23'd1310720,
			23'd1310721, 23'd8388607, 23'd4194304, 23'd65536, 23'd19661, 23'd100000,
			23'd2796202, 23'd5592405, 23'd12345, 23'd400000};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		foreach (directed[i]) send_argument(directed[i]);
		repeat (650) send_argument(random_argument());
		@(negedge clk);
		in_valid <= 0;
		sending_done = 1;
		while (board.want_f.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d arguments over table, cube-root and exponential regions",
			sent);
		$display("%0d result words checked, %0d mismatches", board.checked,
			board.mismatches);
		if (board.mismatches == 0 && board.want_f.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ----- sim.f -----
hw/rtl/skl_pkg.sv
hw/rtl/skl_mul.sv
hw/rtl/skl_seq.sv
hw/rtl/synchrotron_kernel_lookup.sv
hw/rtl/skl_chk.sv
tb/sv/testbench.sv
